FILE: hw/rtl/iga_pkg.sv
// ============================================================================
// iga_pkg
// Shared constants, codes and types for the im2col gather address walk.
// ============================================================================
`default_nettype none

package iga_pkg;

  // Bounds applied to the geometry when a walk starts.
  localparam int unsigned MaxDim      = 1024;
  localparam int unsigned MaxChannels = 1024;
  localparam int unsigned MaxKernel   = 16;

  // Field widths.
  localparam int unsigned DimW   = 11;  // image size and channel count
  localparam int unsigned KerW   = 5;   // kernel size and stride
  localparam int unsigned PadW   = 4;   // padding
  localparam int unsigned PosW   = 12;  // padded positions and signed coordinates
  localparam int unsigned SumW   = 13;  // position plus stride plus kernel
  localparam int unsigned PlaneW = 21;  // one channel plane, up to MaxDim squared
  localparam int unsigned AddrW  = 30;  // flat source address
  localparam int unsigned IdxW   = 3;   // configuration register index

  // Operation codes on the input stream.
  localparam logic OpStart = 1'b0;
  localparam logic OpNext  = 1'b1;

  // Configuration register indexes.
  localparam logic [IdxW-1:0] RegImageHeight  = 3'd0;
  localparam logic [IdxW-1:0] RegImageWidth   = 3'd1;
  localparam logic [IdxW-1:0] RegKernelHeight = 3'd2;
  localparam logic [IdxW-1:0] RegKernelWidth  = 3'd3;
  localparam logic [IdxW-1:0] RegPadRows      = 3'd4;
  localparam logic [IdxW-1:0] RegPadCols      = 3'd5;
  localparam logic [IdxW-1:0] RegStrideRows   = 3'd6;
  localparam logic [IdxW-1:0] RegStrideCols   = 3'd7;

  // Geometry captured at the start of a walk.
  typedef struct packed {
    logic [DimW-1:0]   h;      // image rows
    logic [DimW-1:0]   w;      // image columns
    logic [KerW-1:0]   kh;     // kernel rows
    logic [KerW-1:0]   kw;     // kernel columns
    logic [PadW-1:0]   ph;     // pad rows
    logic [PadW-1:0]   pw;     // pad columns
    logic [KerW-1:0]   sh;     // row stride
    logic [KerW-1:0]   sw;     // column stride
    logic [PosW-1:0]   hp;     // padded image rows
    logic [PosW-1:0]   wp;     // padded image columns
    logic [PlaneW-1:0] plane;  // elements in one channel
  } geom_t;

endpackage

`default_nettype wire

FILE: hw/rtl/im2col_gather_address_walk.sv
// Each next transaction accepted on the slave side has its result registered in the
// output stage, which drives the master side. Throughput: one transaction per cycle,
// start or next, with no gaps; the slave side stalls only while a held result is not taken.
// Reset: no walk is active, configuration and geometry return to their defaults,
// and the output stage is empty.
// ============================================================================
// im2col_gather_address_walk
// Generates the im2col gather address sequence for a padded, strided convolution.
// ============================================================================
`default_nettype none

module im2col_gather_address_walk import iga_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Configuration write port.
  input  wire logic             cfg_we_i,
  input  wire logic [IdxW-1:0]  cfg_idx_i,
  input  wire logic [DimW-1:0]  cfg_data_i,
  // Input stream.
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [15:0]      s_axis_tdata,   // [10:0] channel_count, rest zero
  input  wire logic             s_axis_tuser,   // [0] operation
  // Result stream.
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // [29:0] source_address, rest zero
  output logic [1:0]            m_axis_tuser,   // [0] valid_res, [1] is_padding
  output logic                  m_axis_tlast    // last
);

  // Configuration registers.
  logic [DimW-1:0] cfg_h_q, cfg_w_q;
  logic [KerW-1:0] cfg_kh_q, cfg_kw_q, cfg_sh_q, cfg_sw_q;
  logic [PadW-1:0] cfg_ph_q, cfg_pw_q;

  // Walk state.
  geom_t                  geom_q, geom_d;
  logic                   active_q, active_d;
  logic [DimW-1:0]        chan_total_q, chan_total_d;
  logic [DimW-1:0]        chan_idx_q, chan_idx_d;
  logic [AddrW-1:0]       chan_base_q, chan_base_d;
  logic [KerW-1:0]        win_row_q, win_row_d;
  logic [KerW-1:0]        win_col_q, win_col_d;
  logic signed [PosW-1:0] src_row_q, src_row_d;
  logic signed [PosW-1:0] src_col_q, src_col_d;
  logic [PosW-1:0]        pos_row_q, pos_row_d;  // output row times row stride
  logic [PosW-1:0]        pos_col_q, pos_col_d;  // output column times column stride

  // Output stage.
  logic             out_valid_q;
  logic [AddrW-1:0] out_addr_q, out_addr_d;
  logic             out_vres_q, out_vres_d;
  logic             out_pad_q, out_pad_d;
  logic             out_last_q, out_last_d;

  // Handshake.
  logic s_acc, is_start, is_next, step;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign is_start      = s_acc && (s_axis_tuser == OpStart);
  assign is_next       = s_acc && (s_axis_tuser == OpNext);
  assign step          = is_next && active_q;

  // Start geometry from the configuration registers.
  geom_t           start_geom;
  logic [DimW-1:0] start_total;
  logic [2*DimW-1:0] plane_full;
  logic            start_ok;
  always_comb begin
    start_geom.h  = (cfg_h_q > DimW'(MaxDim)) ? DimW'(MaxDim) : cfg_h_q;
    start_geom.w  = (cfg_w_q > DimW'(MaxDim)) ? DimW'(MaxDim) : cfg_w_q;
    start_geom.kh = (cfg_kh_q > KerW'(MaxKernel)) ? KerW'(MaxKernel) : cfg_kh_q;
    start_geom.kw = (cfg_kw_q > KerW'(MaxKernel)) ? KerW'(MaxKernel) : cfg_kw_q;
    start_geom.ph = cfg_ph_q;
    start_geom.pw = cfg_pw_q;
    start_geom.sh = (cfg_sh_q == '0) ? KerW'(1) : cfg_sh_q;
    start_geom.sw = (cfg_sw_q == '0) ? KerW'(1) : cfg_sw_q;
    start_geom.hp = PosW'(start_geom.h) + PosW'({start_geom.ph, 1'b0});
    start_geom.wp = PosW'(start_geom.w) + PosW'({start_geom.pw, 1'b0});
    plane_full    = (2*DimW)'(start_geom.h) * (2*DimW)'(start_geom.w);
    start_geom.plane = plane_full[PlaneW-1:0];
    start_total = (s_axis_tdata[DimW-1:0] > DimW'(MaxChannels)) ? DimW'(MaxChannels)
                                                                 : s_axis_tdata[DimW-1:0];
    start_ok = (start_total != '0) && (start_geom.h != '0) && (start_geom.w != '0) &&
               (start_geom.kh != '0) && (start_geom.kw != '0) &&
               (PosW'(start_geom.kh) <= start_geom.hp) &&
               (PosW'(start_geom.kw) <= start_geom.wp);
  end

  // Current element: padding test, flat address and end of walk.
  logic             col_more, row_more, last_elem, pad;
  logic [SumW-1:0]  col_reach, row_reach;
  logic [2*DimW-2:0] row_off;
  always_comb begin
    col_reach = SumW'(pos_col_q) + SumW'(geom_q.sw) + SumW'(geom_q.kw);
    row_reach = SumW'(pos_row_q) + SumW'(geom_q.sh) + SumW'(geom_q.kh);
    col_more  = col_reach <= SumW'(geom_q.wp);
    row_more  = row_reach <= SumW'(geom_q.hp);
    last_elem = (chan_idx_q + DimW'(1) == chan_total_q) &&
                (win_row_q + KerW'(1) == geom_q.kh) &&
                (win_col_q + KerW'(1) == geom_q.kw) && !row_more && !col_more;
    pad = src_row_q[PosW-1] || (src_row_q[DimW-1:0] >= geom_q.h) ||
          src_col_q[PosW-1] || (src_col_q[DimW-1:0] >= geom_q.w);
    row_off = (2*DimW-1)'(src_row_q[DimW-2:0]) * (2*DimW-1)'(geom_q.w);
  end

  // Next walk state and the result of a next transaction.
  logic [KerW-1:0] nxt_win_row, nxt_win_col;
  always_comb begin
    geom_d      = geom_q;
    active_d    = active_q;
    chan_total_d = chan_total_q;
    chan_idx_d  = chan_idx_q;
    chan_base_d = chan_base_q;
    win_row_d   = win_row_q;
    win_col_d   = win_col_q;
    src_row_d   = src_row_q;
    src_col_d   = src_col_q;
    pos_row_d   = pos_row_q;
    pos_col_d   = pos_col_q;
    nxt_win_row = win_row_q;
    nxt_win_col = win_col_q;

    out_vres_d = step;
    out_pad_d  = step && pad;
    out_last_d = step && last_elem;
    out_addr_d = (step && !pad) ?
                 chan_base_q + AddrW'(row_off) + AddrW'(src_col_q[DimW-1:0]) : '0;

    if (is_start) begin
      geom_d       = start_geom;
      active_d     = start_ok;
      chan_total_d = start_total;
      chan_idx_d   = '0;
      chan_base_d  = '0;
      win_row_d    = '0;
      win_col_d    = '0;
      pos_row_d    = '0;
      pos_col_d    = '0;
      src_row_d    = -$signed(PosW'(start_geom.ph));
      src_col_d    = -$signed(PosW'(start_geom.pw));
    end else if (step) begin
      if (col_more) begin
        // Next output column.
        pos_col_d = pos_col_q + PosW'(geom_q.sw);
        src_col_d = src_col_q + $signed(PosW'(geom_q.sw));
      end else begin
        pos_col_d = '0;
        if (row_more) begin
          // Next output row of the same kernel tap.
          pos_row_d = pos_row_q + PosW'(geom_q.sh);
          src_row_d = src_row_q + $signed(PosW'(geom_q.sh));
        end else begin
          // Next kernel tap, and next channel after the last tap.
          pos_row_d = '0;
          if (win_col_q + KerW'(1) < geom_q.kw) begin
            nxt_win_col = win_col_q + KerW'(1);
          end else begin
            nxt_win_col = '0;
            if (win_row_q + KerW'(1) < geom_q.kh) begin
              nxt_win_row = win_row_q + KerW'(1);
            end else begin
              nxt_win_row = '0;
              chan_idx_d  = chan_idx_q + DimW'(1);
              chan_base_d = chan_base_q + AddrW'(geom_q.plane);
              if (chan_idx_q + DimW'(1) >= chan_total_q) begin
                active_d = 1'b0;
              end
            end
          end
          win_row_d = nxt_win_row;
          win_col_d = nxt_win_col;
          src_row_d = $signed(PosW'(nxt_win_row)) - $signed(PosW'(geom_q.ph));
        end
        src_col_d = $signed(PosW'(nxt_win_col)) - $signed(PosW'(geom_q.pw));
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_h_q  <= DimW'(1);
      cfg_w_q  <= DimW'(1);
      cfg_kh_q <= KerW'(1);
      cfg_kw_q <= KerW'(1);
      cfg_ph_q <= '0;
      cfg_pw_q <= '0;
      cfg_sh_q <= KerW'(1);
      cfg_sw_q <= KerW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegImageHeight:  cfg_h_q  <= cfg_data_i;
        RegImageWidth:   cfg_w_q  <= cfg_data_i;
        RegKernelHeight: cfg_kh_q <= cfg_data_i[KerW-1:0];
        RegKernelWidth:  cfg_kw_q <= cfg_data_i[KerW-1:0];
        RegPadRows:      cfg_ph_q <= cfg_data_i[PadW-1:0];
        RegPadCols:      cfg_pw_q <= cfg_data_i[PadW-1:0];
        RegStrideRows:   cfg_sh_q <= cfg_data_i[KerW-1:0];
        RegStrideCols:   cfg_sw_q <= cfg_data_i[KerW-1:0];
        default: ;
      endcase
    end
  end

  // Walk state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      geom_q       <= '0;
      chan_total_q <= DimW'(1);
      chan_idx_q   <= '0;
      chan_base_q  <= '0;
      win_row_q    <= '0;
      win_col_q    <= '0;
      src_row_q    <= '0;
      src_col_q    <= '0;
      pos_row_q    <= '0;
      pos_col_q    <= '0;
    end else begin
      active_q     <= active_d;
      geom_q       <= geom_d;
      chan_total_q <= chan_total_d;
      chan_idx_q   <= chan_idx_d;
      chan_base_q  <= chan_base_d;
      win_row_q    <= win_row_d;
      win_col_q    <= win_col_d;
      src_row_q    <= src_row_d;
      src_col_q    <= src_col_d;
      pos_row_q    <= pos_row_d;
      pos_col_q    <= pos_col_d;
    end
  end

  // Output stage: loaded by each next transaction, emptied when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (is_next) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_next) begin
      out_addr_q <= out_addr_d;
      out_vres_q <= out_vres_d;
      out_pad_q  <= out_pad_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_addr_q};
  assign m_axis_tuser  = {out_pad_q, out_vres_q};
  assign m_axis_tlast  = out_last_q;

  // A held result blocks the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while a result is stalled");

  // The final element of a walk closes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && last_elem) |=> !active_q)
    else $error("walk still active after its last element");

  // An active walk never runs past its channel count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (chan_idx_q < chan_total_q))
    else $error("channel index beyond channel count");

  // Padding and empty results carry a zero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_pad_q || !out_vres_q)) |-> (out_addr_q == '0))
    else $error("nonzero address on padding or empty result");

endmodule

`default_nettype wire
